FILE: sv/pixel_intensity_debayer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the intensity/debayer block
// Shared concurrent assertion wrappers clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef PIXEL_INTENSITY_DEBAYER_MACROS_SVH
`define PIXEL_INTENSITY_DEBAYER_MACROS_SVH

// Checked outside reset.
`define PID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Codes and constants of the pixel intensity / 3x3 Bayer interpolation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pid_pkg;

  localparam logic [2:0] MODE_YUV422 = 3'd0;
  localparam logic [2:0] MODE_YUV444 = 3'd1;
  localparam logic [2:0] MODE_RGB8   = 3'd2;
  localparam logic [2:0] MODE_MONO16 = 3'd3;
  localparam logic [2:0] MODE_MONO8  = 3'd4;

  localparam logic [2:0] SITE_GR = 3'd4;
  localparam logic [2:0] SITE_R  = 3'd5;
  localparam logic [2:0] SITE_GB = 3'd6;
  localparam logic [2:0] SITE_B  = 3'd7;

  localparam logic [1:0] ORDER_BGGR = 2'd1;
  localparam logic [1:0] ORDER_GBRG = 2'd2;
  localparam logic [2:0] BGGR_FLIP  = 3'd2;

  // acc / 220 == (acc >> 2) / 55 == ((acc >> 2) * DivMul) >> DivShift
  // exact for (acc >> 2) < 2^20 / 54, kernel sums are at most 255 * 220.
  localparam int unsigned DivShift = 20;
  localparam logic [14:0] DivMul   = 15'd19066;

endpackage

FILE: sv/pixel_intensity_debayer.sv
// ----------------------------------------------------------------------------
// pixel_intensity_debayer
// One 8-bit intensity per 3x3 neighbourhood: YUV pass-through, RGB8 luma,
// MONO16 truncation, MONO8 Bayer kernel interpolation, other modes zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item: format mode, Bayer
//   site type, centre sample and eight neighbours. Output channel
//   out_valid_o/out_ready_i carries intensity_o.
//   bayer_order_we_i writes bayer_order_i into the raw order register (site
//   remap: BGGR, GBRG or none); write it only while no item is in flight.
//   Path: an accepted item goes into the input register, then into the result
//   register that drives out_valid_o; a receiver stall can hold it in between.
//   Throughput: one item per cycle unless stalled; the kernel adder tree and
//   the constant reciprocal multiply for /220 sit between the two registers.
//   Reset clears both valid flags and sets the raw order to none.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more item, and in_ready_o drops once both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pixel_intensity_debayer_macros.svh"

module pixel_intensity_debayer
  import pid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        bayer_order_we_i,
  input  logic [1:0]  bayer_order_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  site_type_i,
  input  logic [15:0] centre_i,
  input  logic [7:0]  east_i,
  input  logic [7:0]  west_i,
  input  logic [7:0]  north_i,
  input  logic [7:0]  south_i,
  input  logic [7:0]  north_west_i,
  input  logic [7:0]  north_east_i,
  input  logic [7:0]  south_west_i,
  input  logic [7:0]  south_east_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  intensity_o
);

  logic [1:0]  order_q;
  logic        s1_valid_q;
  logic [2:0]  mode_q, site_q;
  logic [15:0] centre_q;
  logic [7:0]  e_q, w_q, n_q, s_q, nw_q, ne_q, sw_q, se_q;
  logic        out_valid_q;
  logic [7:0]  intensity_q, intensity_d;

  logic        s2_ready, s1_ready, in_take;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_take    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (bayer_order_we_i) begin
        order_q <= bayer_order_i;
      end
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q   <= mode_i;
      site_q   <= site_type_i;
      centre_q <= centre_i;
      e_q      <= east_i;
      w_q      <= west_i;
      n_q      <= north_i;
      s_q      <= south_i;
      nw_q     <= north_west_i;
      ne_q     <= north_east_i;
      sw_q     <= south_west_i;
      se_q     <= south_east_i;
    end
    if (s2_ready && s1_valid_q) begin
      intensity_q <= intensity_d;
    end
  end

  // site remap by raw order
  logic [2:0] site;
  always_comb begin
    unique case (order_q)
      ORDER_BGGR: site = site_q ^ BGGR_FLIP;
      ORDER_GBRG: site = (site_q == SITE_B) ? SITE_GR : site_q + 3'd1;
      default:    site = site_q;
    endcase
  end

  logic [15:0] c, e, w, n, s, nw, ne, sw, se;
  assign c  = 16'(centre_q[7:0]);
  assign e  = 16'(e_q);
  assign w  = 16'(w_q);
  assign n  = 16'(n_q);
  assign s  = 16'(s_q);
  assign nw = 16'(nw_q);
  assign ne = 16'(ne_q);
  assign sw = 16'(sw_q);
  assign se = 16'(se_q);

  logic        kernel_hit;
  logic [15:0] acc;
  always_comb begin
    kernel_hit = 1'b1;
    unique case (site)
      SITE_GR: acc = 16'd129 * c + 16'd12 * n + 16'd13 * s + 16'd33 * e + 16'd33 * w;
      SITE_R:  acc = 16'd66 * c + 16'd32 * w + 16'd32 * e + 16'd32 * n + 16'd33 * s
                   + 16'd6 * se + 16'd6 * sw + 16'd6 * ne + 16'd7 * nw;
      SITE_GB: acc = 16'd129 * c + 16'd33 * n + 16'd33 * s + 16'd12 * e + 16'd13 * w;
      SITE_B:  acc = 16'd25 * c + 16'd32 * w + 16'd32 * e + 16'd32 * n + 16'd33 * s
                   + 16'd16 * se + 16'd16 * sw + 16'd17 * ne + 16'd17 * nw;
      default: begin
        acc        = '0;
        kernel_hit = 1'b0;
      end
    endcase
  end

  logic [28:0] div_prod;
  logic [7:0]  mono8_val;
  assign div_prod  = 29'(acc[15:2]) * 29'(DivMul);
  assign mono8_val = kernel_hit ? div_prod[DivShift +: 8] : centre_q[7:0];

  logic [15:0] rgb_sum;
  assign rgb_sum = 16'd66 * c + 16'd129 * e + 16'd25 * w;

  always_comb begin
    unique case (mode_q)
      MODE_YUV422, MODE_YUV444: intensity_d = centre_q[7:0];
      MODE_RGB8:                intensity_d = 8'd16 + rgb_sum[15:8];
      MODE_MONO16:              intensity_d = centre_q[11:4];
      MODE_MONO8:               intensity_d = mono8_val;
      default:                  intensity_d = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign intensity_o = intensity_q;

  `PID_ASSERT(a_take_fills_s1, in_valid_i && in_ready_o |=> s1_valid_q, "accepted item lost")
  `PID_ASSERT(a_s1_moves_out, s1_valid_q && s2_ready |=> out_valid_o, "stage 1 item dropped")
  `PID_ASSERT(a_ready_when_free, !s1_valid_q |-> in_ready_o, "ready low with empty input stage")
  `PID_ASSERT(a_bad_mode_zero, s1_valid_q && s2_ready && mode_q > MODE_MONO8 |=> intensity_o == 8'd0, "unknown mode not zero")
  `PID_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && !s1_valid_q, "valid set in reset")

endmodule

FILE: tb/pixel_intensity_debayer_tb.sv
// ----------------------------------------------------------------------------
// pixel_intensity_debayer_tb
// Streams 3x3 neighbourhoods through the intensity/debayer block under every
// raw order setting and compares each intensity with a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_intensity_debayer_tb;
  import pid_pkg::*;

  localparam logic [1:0] ORDER_NONE   = 2'd0;
  localparam logic [1:0] ORDER_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned STALL_LEN   = 80;
  localparam int unsigned PHASE_ITEMS = 292;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  site;
    logic [15:0] centre;
    logic [7:0]  east;
    logic [7:0]  west;
    logic [7:0]  north;
    logic [7:0]  south;
    logic [7:0]  nw;
    logic [7:0]  ne;
    logic [7:0]  sw;
    logic [7:0]  se;
  } nbhd_t;

  typedef struct {
    int unsigned seq;
    logic [7:0]  intensity;
  } due_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        bayer_order_we_i = 1'b0;
  logic [1:0]  bayer_order_i = 2'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  intensity_o;
  nbhd_t       bus_item = '0;

  nbhd_t       nbhd_queue[$];
  due_t        intensity_due[$];
  logic [1:0]  active_order = ORDER_NONE;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          send_hold = 1'b0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned items_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  pixel_intensity_debayer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bayer_order_we_i (bayer_order_we_i),
    .bayer_order_i    (bayer_order_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (bus_item.mode),
    .site_type_i      (bus_item.site),
    .centre_i         (bus_item.centre),
    .east_i           (bus_item.east),
    .west_i           (bus_item.west),
    .north_i          (bus_item.north),
    .south_i          (bus_item.south),
    .north_west_i     (bus_item.nw),
    .north_east_i     (bus_item.ne),
    .south_west_i     (bus_item.sw),
    .south_east_i     (bus_item.se),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .intensity_o      (intensity_o)
  );

  function automatic logic [7:0] calc_intensity(nbhd_t p, logic [1:0] order);
    logic [2:0]  site;
    logic [3:0]  bumped;
    int unsigned c, e, w, n, s, nw, ne, sw, se, acc;
    site = p.site;
    bumped = {1'b0, p.site} + 4'd1;
    if (order == ORDER_BGGR) begin
      site = p.site ^ BGGR_FLIP;
    end else if (order == ORDER_GBRG) begin
      site = bumped[3] ? SITE_GR : bumped[2:0];
    end
    c  = p.centre[7:0];
    e  = p.east;
    w  = p.west;
    n  = p.north;
    s  = p.south;
    nw = p.nw;
    ne = p.ne;
    sw = p.sw;
    se = p.se;
    case (p.mode)
      MODE_YUV422, MODE_YUV444: return p.centre[7:0];
      MODE_RGB8: return 8'(16 + (66 * c + 129 * e + 25 * w) / 256);
      MODE_MONO16: return p.centre[11:4];
      MODE_MONO8: begin
        case (site)
          SITE_GR: acc = 129 * c + 12 * n + 13 * s + 33 * e + 33 * w;
          SITE_R:  acc = 66 * c + 32 * w + 32 * e + 32 * n + 33 * s
                         + 6 * se + 6 * sw + 6 * ne + 7 * nw;
          SITE_GB: acc = 129 * c + 33 * n + 33 * s + 12 * e + 13 * w;
          SITE_B:  acc = 25 * c + 32 * w + 32 * e + 32 * n + 33 * s
                         + 16 * se + 16 * sw + 17 * ne + 17 * nw;
          default: return p.centre[7:0];
        endcase
        return 8'(acc / 220);
      end
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic nbhd_t rand_nbhd();
    nbhd_t       p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) p.mode = MODE_MONO8;
    else if (r < 60) p.mode = MODE_RGB8;
    else if (r < 68) p.mode = MODE_MONO16;
    else if (r < 76) p.mode = MODE_YUV422;
    else if (r < 84) p.mode = MODE_YUV444;
    else p.mode = 3'($urandom_range(5, 7));
    p.site = ($urandom_range(3) != 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
    r = $urandom_range(9);
    p.centre = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(65535));
    p.east  = rand_byte();
    p.west  = rand_byte();
    p.north = rand_byte();
    p.south = rand_byte();
    p.nw    = rand_byte();
    p.ne    = rand_byte();
    p.sw    = rand_byte();
    p.se    = rand_byte();
    return p;
  endfunction

  function automatic nbhd_t mk_nbhd(logic [2:0] mode, logic [2:0] site, logic [15:0] centre,
                                    logic [7:0] fill);
    nbhd_t p;
    p = '{mode: mode, site: site, centre: centre, east: fill, west: fill, north: fill,
          south: fill, nw: fill, ne: fill, sw: fill, se: fill};
    return p;
  endfunction

  task automatic report_mismatch(string what, int unsigned seq, logic [7:0] got,
                                 logic [7:0] want);
    $display("mismatch: %s, item %0d: got %0d, expected %0d", what, seq, got, want);
    err_cnt++;
  endtask

  task automatic write_order(logic [1:0] value);
    @(posedge clk_i);
    bayer_order_we_i <= 1'b1;
    bayer_order_i    <= value;
    @(posedge clk_i);
    bayer_order_we_i <= 1'b0;
    active_order = value;
  endtask

  task automatic drain();
    while (nbhd_queue.size() != 0 || in_valid_i || intensity_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin : drive_items
    logic took;
    took = in_valid_i && in_ready_o;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (took) begin
        intensity_due.push_back('{seq: items_taken,
                                  intensity: calc_intensity(bus_item, active_order)});
        items_taken++;
      end
      if (!in_valid_i || took) begin
        if (nbhd_queue.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          bus_item   <= nbhd_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    due_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (intensity_due.size() == 0) begin
          report_mismatch("unexpected result", 0, intensity_o, 8'd0);
        end else begin
          want = intensity_due.pop_front();
          if (intensity_o !== want.intensity)
            report_mismatch("intensity", want.seq, intensity_o, want.intensity);
        end
      end
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        stall_left = STALL_LEN;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pixel_intensity_debayer_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [1:0] phase_order[6];
    phase_order = '{ORDER_BGGR, ORDER_GBRG, ORDER_UNUSED, ORDER_NONE, ORDER_GBRG, ORDER_BGGR};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 7;
    recv_idle_pct = 52;

    // all kernels at full scale, passthrough sites with a set high byte
    for (int s = 0; s < 8; s++) nbhd_queue.push_back(mk_nbhd(MODE_MONO8, 3'(s), 16'hFFFF, 8'hFF));
    for (int s = 4; s < 8; s++) nbhd_queue.push_back(mk_nbhd(MODE_MONO8, 3'(s), 16'h0000, 8'hFF));
    nbhd_queue.push_back(mk_nbhd(MODE_YUV422, SITE_R, 16'hFF80, 8'h00));
    nbhd_queue.push_back(mk_nbhd(MODE_YUV444, SITE_B, 16'h00FF, 8'hAA));
    nbhd_queue.push_back(mk_nbhd(MODE_RGB8, SITE_GR, 16'hFFFF, 8'hFF));
    nbhd_queue.push_back(mk_nbhd(MODE_RGB8, SITE_GB, 16'h0000, 8'h00));
    nbhd_queue.push_back(mk_nbhd(MODE_MONO16, SITE_GR, 16'hFFFF, 8'h00));
    nbhd_queue.push_back(mk_nbhd(MODE_MONO16, SITE_R, 16'h0000, 8'hFF));
    nbhd_queue.push_back(mk_nbhd(MODE_MONO16, SITE_B, 16'hABCD, 8'h55));
    for (int m = 5; m < 8; m++) nbhd_queue.push_back(mk_nbhd(3'(m), SITE_R, 16'hFFFF, 8'hFF));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 52;
        recv_idle_pct = 7;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_order(phase_order[ph]);
      @(negedge clk_i);
      for (int i = 0; i < PHASE_ITEMS; i++) nbhd_queue.push_back(rand_nbhd());
      // long receiver stall while items keep coming
      if (ph == 0) stall_req = 1'b1;
      // sender pause until the pipeline is empty
      if (ph == 3) begin
        while (nbhd_queue.size() > PHASE_ITEMS / 2) @(negedge clk_i);
        send_hold = 1'b1;
        while (in_valid_i || intensity_due.size() != 0) @(negedge clk_i);
        repeat (5) @(negedge clk_i);
        send_hold = 1'b0;
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("pixel_intensity_debayer_tb: PASS");
    end else begin
      $display("pixel_intensity_debayer_tb: FAIL");
    end
    $finish;
  end

endmodule
